@@ rtl/core/imu_avg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_avg_pkg: shared constants for the imu start-up mean averager
// Sample, mean and count widths, axis count and configuration register indexes.
// ----------------------------------------------------------------------------
package imu_avg_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 8;
    localparam int MEAN_W    = SAMPLE_W + FRAC_BITS;
    localparam int DIFF_W    = MEAN_W + 1;
    localparam int COUNT_W   = 11;
    localparam int LIMIT_W   = 10;
    localparam int NUM_AXES  = 6;
    localparam int AXIS_W    = $clog2(NUM_AXES);
    localparam int STEP_W    = $clog2(DIFF_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_FIRST = COUNT_W'(2);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

endpackage

@@ rtl/core/imu_startup_mean_averager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_startup_mean_averager: running mean of six imu axes for start-up calib
// Incremental mean per axis with 8 fraction bits, using one shared
// restoring divider stepped one quotient bit per cycle.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        slave      i_in_valid / o_in_stall    i_acc_*, i_gyr_* (16b signed)
//  out       master     o_out_valid / i_out_stall  o_avg_* (24b), o_samples_seen,
//                                                  o_calib_done
//  cfg       slave      i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  an averaging word works the six axes in turn on the one shared divider:
//  each axis needs a setup step, 25 divider steps and an apply step.
//  a first, disabled or post-completion word skips the divider entirely.
//  reset (synchronous, active low) clears means, sets count to 1.
//  a word waits in the working state until the output register is free;
//  o_in_stall is high from accept until the result moves to the output.
// ----------------------------------------------------------------------------
module imu_startup_mean_averager (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [imu_avg_pkg::SAMPLE_W-1:0] i_acc_x,
    input  logic signed [imu_avg_pkg::SAMPLE_W-1:0] i_acc_y,
    input  logic signed [imu_avg_pkg::SAMPLE_W-1:0] i_acc_z,
    input  logic signed [imu_avg_pkg::SAMPLE_W-1:0] i_gyr_x,
    input  logic signed [imu_avg_pkg::SAMPLE_W-1:0] i_gyr_y,
    input  logic signed [imu_avg_pkg::SAMPLE_W-1:0] i_gyr_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [imu_avg_pkg::MEAN_W-1:0]   o_avg_acc_x,
    output logic signed [imu_avg_pkg::MEAN_W-1:0]   o_avg_acc_y,
    output logic signed [imu_avg_pkg::MEAN_W-1:0]   o_avg_acc_z,
    output logic signed [imu_avg_pkg::MEAN_W-1:0]   o_avg_gyr_x,
    output logic signed [imu_avg_pkg::MEAN_W-1:0]   o_avg_gyr_y,
    output logic signed [imu_avg_pkg::MEAN_W-1:0]   o_avg_gyr_z,
    output logic        [imu_avg_pkg::COUNT_W-1:0]  o_samples_seen,
    output logic                                   o_calib_done,
    input  logic                                   i_cfg_we,
    input  logic        [imu_avg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [imu_avg_pkg::LIMIT_W-1:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_PUSH  = 5'b10000
    } t_state;

    t_state r_state;

    logic                                  r_enable;
    logic        [imu_avg_pkg::LIMIT_W-1:0] r_limit;

    logic signed [imu_avg_pkg::MEAN_W-1:0]   r_mean [imu_avg_pkg::NUM_AXES];
    logic signed [imu_avg_pkg::SAMPLE_W-1:0] r_smp  [imu_avg_pkg::NUM_AXES];
    logic        [imu_avg_pkg::COUNT_W-1:0]  r_cnt;
    logic                                  r_first;
    logic                                  r_done;

    logic        [imu_avg_pkg::AXIS_W-1:0]   r_axis;
    logic        [imu_avg_pkg::STEP_W-1:0]   r_step;
    logic        [imu_avg_pkg::COUNT_W-1:0]  r_rem;
    logic        [imu_avg_pkg::DIFF_W-1:0]   r_quo;
    logic                                  r_neg;

    logic                                  r_out_valid;
    logic signed [imu_avg_pkg::MEAN_W-1:0]   r_out_mean [imu_avg_pkg::NUM_AXES];
    logic        [imu_avg_pkg::COUNT_W-1:0]  r_out_cnt;
    logic                                  r_out_done;

    logic                                  in_acc;
    logic                                  out_free;
    logic signed [imu_avg_pkg::DIFF_W-1:0]   scaled;
    logic signed [imu_avg_pkg::DIFF_W-1:0]   diff;
    logic        [imu_avg_pkg::DIFF_W-1:0]   diff_mag;
    logic        [imu_avg_pkg::COUNT_W:0]    trial;
    logic        [imu_avg_pkg::COUNT_W:0]    trial_sub;
    logic                                  trial_ge;
    logic        [imu_avg_pkg::COUNT_W-1:0]  n_rem;
    logic        [imu_avg_pkg::DIFF_W-1:0]   n_quo;
    logic signed [imu_avg_pkg::DIFF_W-1:0]   quo_signed;
    logic signed [imu_avg_pkg::DIFF_W-1:0]   n_mean_ext;
    logic        [imu_avg_pkg::COUNT_W-1:0]  n_cnt;
    logic                                  last_axis;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // difference of scaled sample and current mean for the axis in work
    always_comb begin
        scaled   = imu_avg_pkg::DIFF_W'(signed'({r_smp[r_axis],
                                                 {imu_avg_pkg::FRAC_BITS{1'b0}}}));
        diff     = scaled - imu_avg_pkg::DIFF_W'(r_mean[r_axis]);
        diff_mag = diff[imu_avg_pkg::DIFF_W-1] ? imu_avg_pkg::DIFF_W'(-diff)
                                              : imu_avg_pkg::DIFF_W'(diff);
    end

    // one restoring step of the shared divider
    always_comb begin
        trial     = {r_rem, r_quo[imu_avg_pkg::DIFF_W-1]};
        trial_sub = trial - {1'b0, r_cnt};
        trial_ge  = trial >= {1'b0, r_cnt};
        n_rem     = trial_ge ? trial_sub[imu_avg_pkg::COUNT_W-1:0]
                             : trial[imu_avg_pkg::COUNT_W-1:0];
        n_quo     = {r_quo[imu_avg_pkg::DIFF_W-2:0], trial_ge};
    end

    always_comb begin
        quo_signed = r_neg ? -signed'(r_quo) : signed'(r_quo);
        n_mean_ext = imu_avg_pkg::DIFF_W'(r_mean[r_axis]) + quo_signed;
        n_cnt      = (r_cnt < imu_avg_pkg::COUNT_MAX) ? r_cnt + 1'b1 : r_cnt;
        last_axis  = r_axis == imu_avg_pkg::AXIS_W'(imu_avg_pkg::NUM_AXES - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_limit  <= imu_avg_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                imu_avg_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                imu_avg_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < imu_avg_pkg::NUM_AXES; i++) begin
                r_mean[i] <= '0;
            end
            r_cnt   <= imu_avg_pkg::COUNT_RESET;
            r_first <= 1'b1;
            r_done  <= 1'b0;
            r_axis  <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_smp[0] <= i_acc_x;
                        r_smp[1] <= i_acc_y;
                        r_smp[2] <= i_acc_z;
                        r_smp[3] <= i_gyr_x;
                        r_smp[4] <= i_gyr_y;
                        r_smp[5] <= i_gyr_z;
                        r_axis   <= '0;
                        if (!r_enable || r_done) begin
                            r_state <= ST_PUSH;
                        end else if (r_first) begin
                            r_mean[0] <= {i_acc_x, {imu_avg_pkg::FRAC_BITS{1'b0}}};
                            r_mean[1] <= {i_acc_y, {imu_avg_pkg::FRAC_BITS{1'b0}}};
                            r_mean[2] <= {i_acc_z, {imu_avg_pkg::FRAC_BITS{1'b0}}};
                            r_mean[3] <= {i_gyr_x, {imu_avg_pkg::FRAC_BITS{1'b0}}};
                            r_mean[4] <= {i_gyr_y, {imu_avg_pkg::FRAC_BITS{1'b0}}};
                            r_mean[5] <= {i_gyr_z, {imu_avg_pkg::FRAC_BITS{1'b0}}};
                            r_cnt     <= imu_avg_pkg::COUNT_FIRST;
                            r_first   <= 1'b0;
                            r_done    <= imu_avg_pkg::COUNT_FIRST > {1'b0, r_limit};
                            r_state   <= ST_PUSH;
                        end else begin
                            r_state <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP: begin
                    r_neg   <= diff[imu_avg_pkg::DIFF_W-1];
                    r_quo   <= diff_mag;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step + 1'b1;
                    if (r_step == imu_avg_pkg::STEP_W'(imu_avg_pkg::DIFF_W - 1)) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    // mean stays within the sample range, so the top bit drops
                    r_mean[r_axis] <= n_mean_ext[imu_avg_pkg::MEAN_W-1:0];
                    if (last_axis) begin
                        r_cnt   <= n_cnt;
                        r_done  <= n_cnt > {1'b0, r_limit};
                        r_state <= ST_PUSH;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= ST_SETUP;
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register, loaded when the result leaves the working state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUSH && out_free) begin
            for (int i = 0; i < imu_avg_pkg::NUM_AXES; i++) begin
                r_out_mean[i] <= r_mean[i];
            end
            r_out_cnt  <= r_cnt;
            r_out_done <= r_done;
        end
    end

    assign o_in_stall     = r_state != ST_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_avg_acc_x    = r_out_mean[0];
    assign o_avg_acc_y    = r_out_mean[1];
    assign o_avg_acc_z    = r_out_mean[2];
    assign o_avg_gyr_x    = r_out_mean[3];
    assign o_avg_gyr_y    = r_out_mean[4];
    assign o_avg_gyr_z    = r_out_mean[5];
    assign o_samples_seen = r_out_cnt;
    assign o_calib_done   = r_out_done;

`ifndef NO_ASSERTIONS
    a_rem_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < r_cnt)
        else $error("divider remainder not below count");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("done flag dropped without reset");

    a_first_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first |-> r_cnt == imu_avg_pkg::COUNT_RESET && !r_done)
        else $error("count moved before first sample");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("accepted word did not hold input stall");
`endif

endmodule

@@ test/imu_startup_mean_averager_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_startup_mean_averager_test: self-checking bench for the start-up averager
// Drives imu sample words in random bursts against a stalling receiver. An
// internal running-mean tracker predicts every result word, and each one is
// checked field by field. Runs through enable and limit settings, including
// early finish and the hold after calibration is done.
// ----------------------------------------------------------------------------
module imu_startup_mean_averager_test;

    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 2500;
    localparam int CHUNKS           = 4;
    localparam int CHUNK_WORDS      = 240;
    localparam int CHUNK_IDLE_WORDS = 190;

    typedef logic [imu_avg_pkg::NUM_AXES-1:0][imu_avg_pkg::SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic                              is_cfg;
        logic [imu_avg_pkg::CFG_IDX_W-1:0] cfg_idx;
        logic [imu_avg_pkg::LIMIT_W-1:0]   cfg_data;
        t_sample                           sample;
    } t_stim;

    typedef struct packed {
        logic [imu_avg_pkg::NUM_AXES-1:0][imu_avg_pkg::MEAN_W-1:0] mean;
        logic [imu_avg_pkg::COUNT_W-1:0]                           count;
        logic                                                      done;
    } t_mean_report;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    t_sample                           in_axis = '0;
    logic                              out_stall = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [imu_avg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [imu_avg_pkg::LIMIT_W-1:0]   cfg_data = '0;

    logic                            o_in_stall;
    logic                            o_out_valid;
    logic [imu_avg_pkg::MEAN_W-1:0]  o_avg_acc_x, o_avg_acc_y, o_avg_acc_z;
    logic [imu_avg_pkg::MEAN_W-1:0]  o_avg_gyr_x, o_avg_gyr_y, o_avg_gyr_z;
    logic [imu_avg_pkg::COUNT_W-1:0] o_samples_seen;
    logic                            o_calib_done;

    t_stim        stim_q [$];
    t_mean_report report_q [$];

    // running-mean tracker
    logic                            pred_enable;
    logic [imu_avg_pkg::LIMIT_W-1:0] pred_limit;
    longint                          pred_mean [imu_avg_pkg::NUM_AXES];
    logic [imu_avg_pkg::COUNT_W-1:0] pred_count;
    logic                            pred_first;
    logic                            pred_finished;

    logic        word_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          quiet_run = 0;
    int          reports_seen = 0;
    int          error_count = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          mode_left = 0;
    int          stall_phase = 0;
    t_stall_mode stall_mode = STALL_NONE;

    string axis_name [imu_avg_pkg::NUM_AXES] =
        '{"acc_x", "acc_y", "acc_z", "gyr_x", "gyr_y", "gyr_z"};

    imu_startup_mean_averager uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_acc_x        (in_axis[0]),
        .i_acc_y        (in_axis[1]),
        .i_acc_z        (in_axis[2]),
        .i_gyr_x        (in_axis[3]),
        .i_gyr_y        (in_axis[4]),
        .i_gyr_z        (in_axis[5]),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_avg_acc_x    (o_avg_acc_x),
        .o_avg_acc_y    (o_avg_acc_y),
        .o_avg_acc_z    (o_avg_acc_z),
        .o_avg_gyr_x    (o_avg_gyr_x),
        .o_avg_gyr_y    (o_avg_gyr_y),
        .o_avg_gyr_z    (o_avg_gyr_z),
        .o_samples_seen (o_samples_seen),
        .o_calib_done   (o_calib_done),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic t_mean_report fold_sample(input t_sample s);
        t_mean_report r;
        longint       scaled;
        int           a;
        if (pred_enable && !pred_finished) begin
            for (a = 0; a < imu_avg_pkg::NUM_AXES; a++) begin
                scaled = longint'($signed(s[a])) * (longint'(1) << imu_avg_pkg::FRAC_BITS);
                if (pred_first) begin
                    pred_mean[a] = scaled;
                end else begin
                    // integer division truncates toward zero
                    pred_mean[a] = pred_mean[a] + (scaled - pred_mean[a]) / longint'(pred_count);
                end
            end
            if (pred_first) begin
                pred_count = imu_avg_pkg::COUNT_FIRST;
                pred_first = 1'b0;
            end else if (pred_count < imu_avg_pkg::COUNT_MAX) begin
                pred_count = pred_count + 1'b1;
            end
            if (pred_count > imu_avg_pkg::COUNT_W'(pred_limit)) begin
                pred_finished = 1'b1;
            end
        end
        for (a = 0; a < imu_avg_pkg::NUM_AXES; a++) begin
            r.mean[a] = imu_avg_pkg::MEAN_W'(pred_mean[a]);
        end
        r.count = pred_count;
        r.done  = pred_finished;
        return r;
    endfunction

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic queue_sample(input int ax, input int ay, input int az,
                                input int gx, input int gy, input int gz);
        t_stim w;
        w = '0;
        w.sample[0] = imu_avg_pkg::SAMPLE_W'(ax);
        w.sample[1] = imu_avg_pkg::SAMPLE_W'(ay);
        w.sample[2] = imu_avg_pkg::SAMPLE_W'(az);
        w.sample[3] = imu_avg_pkg::SAMPLE_W'(gx);
        w.sample[4] = imu_avg_pkg::SAMPLE_W'(gy);
        w.sample[5] = imu_avg_pkg::SAMPLE_W'(gz);
        stim_q.push_back(w);
    endtask

    task automatic queue_cfg(input logic [imu_avg_pkg::CFG_IDX_W-1:0] idx, input int data);
        t_stim w;
        w = '0;
        w.is_cfg   = 1'b1;
        w.cfg_idx  = idx;
        w.cfg_data = imu_avg_pkg::LIMIT_W'(data);
        stim_q.push_back(w);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic int full_range();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // tracker update and input acceptance
    always @(posedge clk) begin : predict_words
        int a;
        word_taken = 1'b0;
        if (!rst_n) begin
            pred_enable   = 1'b1;
            pred_limit    = imu_avg_pkg::LIMIT_RESET;
            for (a = 0; a < imu_avg_pkg::NUM_AXES; a++) begin
                pred_mean[a] = 0;
            end
            pred_count    = imu_avg_pkg::COUNT_RESET;
            pred_first    = 1'b1;
            pred_finished = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    imu_avg_pkg::CFG_ENABLE: pred_enable = cfg_data[0];
                    imu_avg_pkg::CFG_LIMIT:  pred_limit  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !o_in_stall) begin
                word_taken = 1'b1;
                report_q.push_back(fold_sample(in_axis));
            end
        end
    end

    always @(posedge clk) begin : check_reports
        t_mean_report got;
        t_mean_report want;
        int           a;
        if (rst_n && o_out_valid && !out_stall) begin
            got.mean  = {o_avg_gyr_z, o_avg_gyr_y, o_avg_gyr_x,
                         o_avg_acc_z, o_avg_acc_y, o_avg_acc_x};
            got.count = o_samples_seen;
            got.done  = o_calib_done;
            reports_seen++;
            if (report_q.size() == 0) begin
                error_count++;
                $display("%0t ns: result word with nothing expected, count %0d",
                         $time, got.count);
            end else begin
                want = report_q.pop_front();
                for (a = 0; a < imu_avg_pkg::NUM_AXES; a++) begin
                    check_field({"avg_", axis_name[a]}, longint'($signed(want.mean[a])),
                                longint'($signed(got.mean[a])));
                end
                check_field("samples_seen", longint'(want.count), longint'(got.count));
                check_field("calib_done", longint'(want.done), longint'(got.done));
            end
        end
    end

    // sender: bursts of words with random gaps, config writes only when idle
    always @(negedge clk) begin : drive_words
        logic valid_next;
        logic we_next;
        valid_next = in_valid;
        we_next    = 1'b0;
        if (rst_n) begin
            if (in_valid && word_taken) begin
                void'(stim_q.pop_front());
                valid_next = 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : 0;
                end
            end
            if (valid_next || report_q.size() != 0) begin
                quiet_run = 0;
            end else begin
                quiet_run++;
            end
            if (!valid_next && stim_q.size() != 0) begin
                if (stim_q[0].is_cfg) begin
                    if (quiet_run >= SETTLE_CYCLES) begin
                        we_next = 1'b1;
                        cfg_idx  <= stim_q[0].cfg_idx;
                        cfg_data <= stim_q[0].cfg_data;
                        void'(stim_q.pop_front());
                        quiet_run = 0;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    valid_next = 1'b1;
                    in_axis <= stim_q[0].sample;
                end
            end
        end
        in_valid <= valid_next;
        cfg_we   <= we_next;
    end

    // receiver: changing stall patterns plus one long hold-off
    always @(negedge clk) begin : drive_stall
        logic stall_next;
        stall_next = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 400);
            end else begin
                mode_left--;
            end
            stall_phase = (stall_phase + 1) % 7;
            case (stall_mode)
                STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: stall_next = (stall_phase < 3);
                default:        stall_next = 1'b0;
            endcase
            if (!hold_done && reports_seen >= 300) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES;
                stall_next = 1'b1;
            end
        end
        out_stall <= stall_next;
    end

    initial begin : run_test
        int v [imu_avg_pkg::NUM_AXES];
        int base [imu_avg_pkg::NUM_AXES];
        int spread;
        int chunk;
        int n;
        int a;
        int pick;

        queue_cfg(imu_avg_pkg::CFG_ENABLE, 1);
        queue_cfg(imu_avg_pkg::CFG_LIMIT, 1023);

        // directed: first load, full-scale swings, small values on both signs
        queue_sample(-32768, 32767, 0, -1, 1, 21845);
        queue_sample(32767, 32767, 32767, 32767, 32767, 32767);
        queue_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_sample(32767, -32768, 32767, -32768, 0, -1);
        queue_sample(0, 0, 0, 0, 0, 0);
        queue_sample(-1, -1, -1, -1, -1, -1);
        queue_sample(1, 1, 1, 1, 1, 1);
        queue_sample(-21846, 21845, -1, 1, 32767, -32768);
        for (n = 0; n < 4; n++) begin
            queue_sample(-2, 3, -5, 7, -11, 13);
        end

        // disabled words are ignored; limit extremes written while disabled
        queue_cfg(imu_avg_pkg::CFG_ENABLE, 0);
        queue_sample(32767, 32767, 32767, 32767, 32767, 32767);
        queue_cfg(imu_avg_pkg::CFG_LIMIT, 0);
        queue_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_cfg(imu_avg_pkg::CFG_LIMIT, 1);
        queue_sample(0, 1, -1, 2, -2, 3);
        queue_cfg(imu_avg_pkg::CFG_LIMIT, 1023);
        queue_cfg(imu_avg_pkg::CFG_ENABLE, 1);
        queue_sample(100, -100, 200, -200, 300, -300);

        // random: mostly noisy samples around a resting level per axis
        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            for (a = 0; a < imu_avg_pkg::NUM_AXES; a++) begin
                base[a] = full_range();
            end
            spread = 1 << $urandom_range(0, 10);
            for (n = 0; n < CHUNK_WORDS; n++) begin
                pick = $urandom_range(0, 19);
                for (a = 0; a < imu_avg_pkg::NUM_AXES; a++) begin
                    if (pick < 12) begin
                        v[a] = base[a] + int'($urandom_range(0, 2 * spread)) - spread;
                    end else if (pick < 17) begin
                        v[a] = full_range();
                    end else begin
                        v[a] = pick_extreme();
                    end
                end
                queue_sample(v[0], v[1], v[2], v[3], v[4], v[5]);
            end
            queue_cfg(imu_avg_pkg::CFG_ENABLE, 0);
            for (n = 0; n < CHUNK_IDLE_WORDS; n++) begin
                queue_sample(full_range(), full_range(), full_range(),
                             full_range(), full_range(), full_range());
            end
            queue_cfg(imu_avg_pkg::CFG_LIMIT, $urandom_range(1000, 1023));
            queue_cfg(imu_avg_pkg::CFG_ENABLE, 1);
        end

        // limit dropped under the count: next word averages and finishes
        queue_cfg(imu_avg_pkg::CFG_LIMIT, $urandom_range(2, 900));
        for (n = 0; n < 12; n++) begin
            queue_sample(full_range(), full_range(), full_range(),
                         full_range(), full_range(), full_range());
        end
        queue_cfg(imu_avg_pkg::CFG_ENABLE, 0);
        for (n = 0; n < 3; n++) begin
            queue_sample(pick_extreme(), pick_extreme(), pick_extreme(),
                         pick_extreme(), pick_extreme(), pick_extreme());
        end
        queue_cfg(imu_avg_pkg::CFG_LIMIT, 1023);
        queue_cfg(imu_avg_pkg::CFG_ENABLE, 1);
        for (n = 0; n < 6; n++) begin
            queue_sample(full_range(), full_range(), full_range(),
                         full_range(), full_range(), full_range());
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        wait (stim_q.size() == 0 && report_q.size() == 0 && !in_valid);
        repeat (50) @(posedge clk);
        if (error_count == 0) begin
            $display("imu_startup_mean_averager_test: done, clean");
        end else begin
            $display("imu_startup_mean_averager_test: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #25_000_000;
        $display("imu_startup_mean_averager_test: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/imu_avg_pkg.sv
rtl/core/imu_startup_mean_averager.sv
test/imu_startup_mean_averager_test.sv
